>>> rtl/utf8sd_pkg.sv
// shared types, constants and lead byte decode for the utf-8 stream decoder
package utf8sd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 31;
  localparam int unsigned LEN_W  = 3;
  localparam int unsigned PAY_W  = 6;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_LEAD = 2'd1,
    STATUS_BAD_CONT = 2'd2
  } status_t;

  // sequence length from the lead byte prefix, 0 when it cannot lead
  function automatic logic [LEN_W-1:0] lead_length(input logic [BYTE_W-1:0] b);
    logic [LEN_W-1:0] len;
    len = 3'd0;
    if ((b & 8'h80) == 8'h00)      len = 3'd1;
    else if ((b & 8'hE0) == 8'hC0) len = 3'd2;
    else if ((b & 8'hF0) == 8'hE0) len = 3'd3;
    else if ((b & 8'hF8) == 8'hF0) len = 3'd4;
    else if ((b & 8'hFC) == 8'hF8) len = 3'd5;
    else if ((b & 8'hFE) == 8'hFC) len = 3'd6;
    return len;
  endfunction

  function automatic logic [BYTE_W-2:0] lead_payload_mask(input logic [LEN_W-1:0] len);
    logic [BYTE_W-2:0] m;
    case (len)
      3'd1:    m = 7'h7F;
      3'd2:    m = 7'h1F;
      3'd3:    m = 7'h0F;
      3'd4:    m = 7'h07;
      3'd5:    m = 7'h03;
      3'd6:    m = 7'h01;
      default: m = 7'h00;
    endcase
    return m;
  endfunction

endpackage

>>> rtl/utf8_stream_decoder.sv
// utf-8 stream decoder, six byte form, one byte per word in, one code point per word out
//
//   channel | handshake          | payload
//   --------+--------------------+-----------------------------------------
//   input   | in_valid, in_ready | data_byte[7:0]
//   output  | out_valid, out_ready | code_point[30:0], seq_length[2:0], status[1:0]
//
// one byte per cycle sustained while no result is held back by a stalled output; a byte
// is held in the input register and then decoded into the result register. reset clears
// all sequence state and both valid flags.
// a stalled output only holds the input register when the byte there would produce a
// result (a finished sequence or an invalid lead byte); other bytes keep flowing.
module utf8_stream_decoder
  import utf8sd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [BYTE_W-1:0]    data_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CP_W-1:0]      code_point,
  output logic [LEN_W-1:0]     seq_length,
  output logic [1:0]           status
);

  // input register
  logic              in_reg_valid;
  logic [BYTE_W-1:0] in_reg_byte;

  // sequence state
  logic [LEN_W-1:0] bytes_pending, bytes_pending_next;
  logic [LEN_W-1:0] total_length, total_length_next;
  logic [CP_W-1:0]  accumulator, accumulator_next;
  logic             continuation_error, continuation_error_next;

  // result register
  logic             res_valid;
  logic [CP_W-1:0]  res_cp;
  logic [LEN_W-1:0] res_len;
  status_t          res_status;

  logic             emit;
  logic [CP_W-1:0]  emit_cp;
  logic [LEN_W-1:0] emit_len;
  status_t          emit_status;
  logic             step;

  logic [LEN_W-1:0] lead_len;
  logic [CP_W-1:0]  shifted;

  always_comb begin
    lead_len = lead_length(in_reg_byte);
    shifted  = {accumulator[CP_W-PAY_W-1:0], in_reg_byte[PAY_W-1:0]};

    bytes_pending_next      = bytes_pending;
    total_length_next       = total_length;
    accumulator_next        = accumulator;
    continuation_error_next = continuation_error;
    emit        = 1'b0;
    emit_cp     = '0;
    emit_len    = '0;
    emit_status = STATUS_OK;

    if (bytes_pending == '0) begin
      if (lead_len == '0) begin
        emit        = 1'b1;
        emit_status = STATUS_BAD_LEAD;
      end else if (lead_len == 3'd1) begin
        emit     = 1'b1;
        emit_cp  = {{(CP_W-BYTE_W+1){1'b0}}, in_reg_byte[BYTE_W-2:0]};
        emit_len = 3'd1;
        continuation_error_next = 1'b0;
      end else begin
        accumulator_next = {{(CP_W-BYTE_W+1){1'b0}},
                            in_reg_byte[BYTE_W-2:0] & lead_payload_mask(lead_len)};
        total_length_next       = lead_len;
        continuation_error_next = 1'b0;
        bytes_pending_next      = lead_len - 3'd1;
      end
    end else begin
      // low six bits count even when the top bits are wrong
      continuation_error_next = continuation_error | (in_reg_byte[7:6] != 2'b10);
      accumulator_next   = shifted;
      bytes_pending_next = bytes_pending - 3'd1;
      if (bytes_pending == 3'd1) begin
        emit        = 1'b1;
        emit_cp     = shifted;
        emit_len    = total_length;
        emit_status = continuation_error_next ? STATUS_BAD_CONT : STATUS_OK;
        accumulator_next        = '0;
        total_length_next       = '0;
        continuation_error_next = 1'b0;
      end
    end
  end

  assign step     = in_reg_valid && (!emit || !res_valid || out_ready);
  assign in_ready = !in_reg_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid       <= 1'b0;
      res_valid          <= 1'b0;
      bytes_pending      <= '0;
      total_length       <= '0;
      accumulator        <= '0;
      continuation_error <= 1'b0;
    end else begin
      if (in_ready) begin
        in_reg_valid <= in_valid;
      end
      if (step) begin
        bytes_pending      <= bytes_pending_next;
        total_length       <= total_length_next;
        accumulator        <= accumulator_next;
        continuation_error <= continuation_error_next;
      end
      if (step && emit) begin
        res_valid <= 1'b1;
      end else if (out_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_reg_byte <= data_byte;
    end
    if (step && emit) begin
      res_cp     <= emit_cp;
      res_len    <= emit_len;
      res_status <= emit_status;
    end
  end

  assign out_valid  = res_valid;
  assign code_point = res_cp;
  assign seq_length = res_len;
  assign status     = res_status;

  // between sequences nothing is left over
  assert property (@(posedge clk) disable iff (rst)
    (bytes_pending == '0) |-> (total_length == '0 && !continuation_error))
    else $error("sequence state not cleared while idle");

  assert property (@(posedge clk) disable iff (rst)
    (bytes_pending != '0) |-> (bytes_pending < total_length && total_length <= 3'd6))
    else $error("pending count out of range for sequence length");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STATUS_BAD_LEAD) |-> (code_point == '0 && seq_length == '0))
    else $error("invalid lead result carries data");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != STATUS_BAD_LEAD) |-> (seq_length != '0 && seq_length <= 3'd6))
    else $error("decoded result has bad length");

endmodule
